>>> rtl/core/tmb_pkg.sv
// shared types and constants for the trail ribbon mesh builder
// no dependencies; imported by every module of the block
package tmb_pkg;

  localparam int TRAIL_POINTS = 64;
  localparam int NUM_W        = 6;
  localparam int CNT_W        = 7;
  localparam int IDX_W        = 7;
  localparam int DIV_STEPS    = 15;
  localparam int QDEPTH       = 4;
  localparam int QPTR_W       = $clog2(QDEPTH);
  localparam logic [15:0] Q15_ONE = 16'h8000;

  // register index, taken from paddr bit 2
  localparam logic REG_LIFE_TIME   = 1'b0;
  localparam logic REG_COLOR_ALPHA = 1'b1;

  typedef struct packed {
    logic [31:0] life_time;
    logic [15:0] color_alpha;
  } cfg_t;

  // one finished point handed from front to back
  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic [15:0]        alpha;
    logic [15:0]        u;
  } pt_rec_t;

  typedef enum logic [1:0] {
    PH_BASE,
    PH_TIP,
    PH_TRI_A,
    PH_TRI_B
  } phase_e;

  typedef enum logic {
    KIND_VERTEX   = 1'b0,
    KIND_TRIANGLE = 1'b1
  } kind_e;

endpackage

>>> rtl/core/tmb_cfg.sv
// configuration registers behind the apb-style port
// depends on tmb_pkg
module tmb_cfg import tmb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  logic [31:0] life_q;
  logic [15:0] alpha_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      life_q  <= 32'd65536;
      alpha_q <= Q15_ONE;
    end else if (wr_en) begin
      case (paddr[2])
        REG_LIFE_TIME:   life_q  <= pwdata;
        REG_COLOR_ALPHA: alpha_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_LIFE_TIME:   prdata = life_q;
      REG_COLOR_ALPHA: prdata = {16'd0, alpha_q};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg_o.life_time   = life_q;
  assign cfg_o.color_alpha = alpha_q;

endmodule

>>> rtl/core/tmb_front.sv
// front: accepts points, drops the ones that give nothing, divides and blends
// depends on tmb_pkg; feeds tmb_queue
module tmb_front import tmb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               push,
  output logic               full,
  input  logic [NUM_W-1:0]   point_number_i,
  input  logic [CNT_W-1:0]   point_count_i,
  input  logic signed [31:0] base_x_i,
  input  logic signed [31:0] base_y_i,
  input  logic signed [31:0] base_z_i,
  input  logic signed [31:0] tip_x_i,
  input  logic signed [31:0] tip_y_i,
  input  logic signed [31:0] tip_z_i,
  input  logic [31:0]        point_age_i,
  output logic               q_push_o,
  output pt_rec_t            q_data_o,
  input  logic               q_full_i
);

  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic [31:0]        rem_a;
    logic [14:0]        q_a;
    logic               zero_a;
    logic [NUM_W-1:0]   rem_u;
    logic [NUM_W-1:0]   d;
    logic [14:0]        q_u;
    logic               one_u;
  } div_t;

  // one restoring step for both quotients
  function automatic div_t div_step(div_t s, logic [31:0] life);
    logic [32:0]      ra;
    logic [NUM_W:0]   ru;
    div_t             n;
    n  = s;
    ra = {s.rem_a, 1'b0};
    ru = {s.rem_u, 1'b0};
    if (ra >= {1'b0, life}) begin
      n.rem_a = 32'(ra - {1'b0, life});
      n.q_a   = {s.q_a[13:0], 1'b1};
    end else begin
      n.rem_a = ra[31:0];
      n.q_a   = {s.q_a[13:0], 1'b0};
    end
    if (ru >= {1'b0, s.d}) begin
      n.rem_u = NUM_W'(ru - {1'b0, s.d});
      n.q_u   = {s.q_u[13:0], 1'b1};
    end else begin
      n.rem_u = ru[NUM_W-1:0];
      n.q_u   = {s.q_u[13:0], 1'b0};
    end
    return n;
  endfunction

  logic               adv;
  logic [CNT_W-1:0]   cnt_sat;
  logic               emit;
  div_t               in_st;

  div_t               dv_q   [0:DIV_STEPS];
  logic               dvld_q [0:DIV_STEPS];

  // blend stages
  logic               a_vld_q, b_vld_q, c_vld_q;
  logic [15:0]        ratio_q, u_a_q, u_b_q, acap_q;
  logic [NUM_W-1:0]   num_a_q, num_b_q;
  logic signed [31:0] bx_a_q, by_a_q, bz_a_q, bx_b_q, by_b_q, bz_b_q;
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [49:0] px_q, py_q, pz_q;
  logic [31:0]        pa_q;
  logic [15:0]        ratio_d, u_d, acap_d;
  logic signed [49:0] px_d, py_d, pz_d;
  pt_rec_t            rec_q;

  assign adv      = !(c_vld_q && q_full_i);
  assign full     = !adv;
  assign q_push_o = c_vld_q && !q_full_i;
  assign q_data_o = rec_q;

  always_comb begin
    cnt_sat = (point_count_i > CNT_W'(TRAIL_POINTS)) ? CNT_W'(TRAIL_POINTS) : point_count_i;
    emit    = (cnt_sat >= CNT_W'(2)) && ({1'b0, point_number_i} < cnt_sat);
    in_st.num    = point_number_i;
    in_st.bx     = base_x_i;
    in_st.by     = base_y_i;
    in_st.bz     = base_z_i;
    in_st.tx     = tip_x_i;
    in_st.ty     = tip_y_i;
    in_st.tz     = tip_z_i;
    in_st.rem_a  = point_age_i;
    in_st.q_a    = '0;
    // age at or past lifetime, or a zero lifetime, fades the point fully
    in_st.zero_a = (cfg_i.life_time == 32'd0) || (point_age_i >= cfg_i.life_time);
    in_st.rem_u  = point_number_i;
    in_st.d      = NUM_W'(cnt_sat - CNT_W'(1));
    in_st.q_u    = '0;
    in_st.one_u  = ({1'b0, point_number_i} == CNT_W'(cnt_sat - CNT_W'(1)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STEPS; k++) dvld_q[k] <= 1'b0;
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
    end else if (adv) begin
      dvld_q[0] <= push && emit;
      for (int k = 1; k <= DIV_STEPS; k++) dvld_q[k] <= dvld_q[k-1];
      a_vld_q <= dvld_q[DIV_STEPS];
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_q[0] <= in_st;
      for (int k = 1; k <= DIV_STEPS; k++) dv_q[k] <= div_step(dv_q[k-1], cfg_i.life_time);
    end
  end

  always_comb begin
    ratio_d = dv_q[DIV_STEPS].zero_a ? 16'd0 : 16'(Q15_ONE - {1'b0, dv_q[DIV_STEPS].q_a});
    u_d     = dv_q[DIV_STEPS].one_u ? Q15_ONE : {1'b0, dv_q[DIV_STEPS].q_u};
    acap_d  = (cfg_i.color_alpha > Q15_ONE) ? Q15_ONE : cfg_i.color_alpha;
    px_d    = dx_q * $signed({1'b0, ratio_q}) + 50'sd16384;
    py_d    = dy_q * $signed({1'b0, ratio_q}) + 50'sd16384;
    pz_d    = dz_q * $signed({1'b0, ratio_q}) + 50'sd16384;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ratio_q <= ratio_d;
      u_a_q   <= u_d;
      acap_q  <= acap_d;
      num_a_q <= dv_q[DIV_STEPS].num;
      bx_a_q  <= dv_q[DIV_STEPS].bx;
      by_a_q  <= dv_q[DIV_STEPS].by;
      bz_a_q  <= dv_q[DIV_STEPS].bz;
      dx_q    <= {dv_q[DIV_STEPS].tx[31], dv_q[DIV_STEPS].tx}
               - {dv_q[DIV_STEPS].bx[31], dv_q[DIV_STEPS].bx};
      dy_q    <= {dv_q[DIV_STEPS].ty[31], dv_q[DIV_STEPS].ty}
               - {dv_q[DIV_STEPS].by[31], dv_q[DIV_STEPS].by};
      dz_q    <= {dv_q[DIV_STEPS].tz[31], dv_q[DIV_STEPS].tz}
               - {dv_q[DIV_STEPS].bz[31], dv_q[DIV_STEPS].bz};

      px_q    <= px_d;
      py_q    <= py_d;
      pz_q    <= pz_d;
      pa_q    <= acap_q * ratio_q + 32'd16384;
      u_b_q   <= u_a_q;
      num_b_q <= num_a_q;
      bx_b_q  <= bx_a_q;
      by_b_q  <= by_a_q;
      bz_b_q  <= bz_a_q;

      // arithmetic shift gives the floor of the rounded quotient
      rec_q.num   <= num_b_q;
      rec_q.bx    <= bx_b_q;
      rec_q.by    <= by_b_q;
      rec_q.bz    <= bz_b_q;
      rec_q.tx    <= bx_b_q + $signed(px_q[46:15]);
      rec_q.ty    <= by_b_q + $signed(py_q[46:15]);
      rec_q.tz    <= bz_b_q + $signed(pz_q[46:15]);
      rec_q.alpha <= pa_q[30:15];
      rec_q.u     <= u_b_q;
    end
  end

endmodule

>>> rtl/core/tmb_queue.sv
// short queue of finished points between front and back
// depends on tmb_pkg
module tmb_queue import tmb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  pt_rec_t wdata_i,
  output logic    full_o,
  input  logic    pop_i,
  output pt_rec_t rdata_o,
  output logic    empty_o
);

  pt_rec_t           mem_q [0:QDEPTH-1];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W+1)'(QDEPTH)) else $error("queue count over depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue popped while empty");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue pushed while full");
`endif

endmodule

>>> rtl/core/tmb_back.sv
// back: walks each queued point through its vertices and triangles
// depends on tmb_pkg; reads tmb_queue
module tmb_back import tmb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pt_rec_t            q_data_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic               result_kind_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic [15:0]        alpha_o,
  output logic [15:0]        tex_u_o,
  output logic               tex_v_o,
  output logic [IDX_W-1:0]   first_index_o,
  output logic [IDX_W-1:0]   second_index_o,
  output logic [IDX_W-1:0]   third_index_o,
  output logic               last_o
);

  typedef struct packed {
    kind_e              kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0]        alpha;
    logic [15:0]        u;
    logic               v;
    logic [IDX_W-1:0]   i0;
    logic [IDX_W-1:0]   i1;
    logic [IDX_W-1:0]   i2;
    logic               last;
  } res_t;

  phase_e           phase_q, phase_d;
  logic             out_vld_q;
  res_t             out_q, res_d;
  logic             load;
  logic [IDX_W-1:0] b;

  assign load    = !q_empty_i && (!out_vld_q || pop);
  assign b       = IDX_W'({q_data_i.num, 1'b0} - 2);
  assign q_pop_o = load && res_d.last;

  always_comb begin
    res_d   = '0;
    phase_d = phase_q;
    case (phase_q)
      PH_BASE: begin
        res_d.kind  = KIND_VERTEX;
        res_d.px    = q_data_i.bx;
        res_d.py    = q_data_i.by;
        res_d.pz    = q_data_i.bz;
        res_d.alpha = q_data_i.alpha;
        res_d.u     = q_data_i.u;
        res_d.v     = 1'b0;
      end
      PH_TIP: begin
        res_d.kind  = KIND_VERTEX;
        res_d.px    = q_data_i.tx;
        res_d.py    = q_data_i.ty;
        res_d.pz    = q_data_i.tz;
        res_d.alpha = q_data_i.alpha;
        res_d.u     = q_data_i.u;
        res_d.v     = 1'b1;
        // the oldest point closes no quad
        res_d.last  = (q_data_i.num == '0);
      end
      PH_TRI_A: begin
        res_d.kind = KIND_TRIANGLE;
        res_d.i0   = b;
        res_d.i1   = b + IDX_W'(1);
        res_d.i2   = b + IDX_W'(2);
      end
      PH_TRI_B: begin
        res_d.kind = KIND_TRIANGLE;
        res_d.i0   = b + IDX_W'(2);
        res_d.i1   = b + IDX_W'(1);
        res_d.i2   = b + IDX_W'(3);
        res_d.last = 1'b1;
      end
      default: ;
    endcase
    if (load) begin
      case (phase_q)
        PH_BASE:  phase_d = PH_TIP;
        PH_TIP:   phase_d = res_d.last ? PH_BASE : PH_TRI_A;
        PH_TRI_A: phase_d = PH_TRI_B;
        PH_TRI_B: phase_d = PH_BASE;
        default:  phase_d = PH_BASE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_BASE;
      out_vld_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load)     out_vld_q <= 1'b1;
      else if (pop) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= res_d;
  end

  assign empty          = !out_vld_q;
  assign result_kind_o  = out_q.kind;
  assign pos_x_o        = out_q.px;
  assign pos_y_o        = out_q.py;
  assign pos_z_o        = out_q.pz;
  assign alpha_o        = out_q.alpha;
  assign tex_u_o        = out_q.u;
  assign tex_v_o        = out_q.v;
  assign first_index_o  = out_q.i0;
  assign second_index_o = out_q.i1;
  assign third_index_o  = out_q.i2;
  assign last_o         = out_q.last;

`ifndef ASSERT_OFF
  a_mid_point_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_BASE |-> !q_empty_i) else $error("point left queue mid walk");
  a_base_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.kind == KIND_VERTEX && !out_q.v |-> !out_q.last)
    else $error("base vertex marked last");
  a_pop_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> phase_q == PH_BASE) else $error("phase not rewound after point");
`endif

endmodule

>>> rtl/core/trail_ribbon_mesh_builder_core.sv
// top level of the trail ribbon mesh builder
// depends on tmb_pkg, tmb_cfg, tmb_front, tmb_queue, tmb_back
//
// channel   direction  handshake           payload
// point     in         push / full         point_number .. point_age
// result    out        empty / pop         result_kind .. last
// config    in         psel/penable/pwrite life_time, color_alpha
//
// a point is registered at entry, then passes the 15-stage divider pipeline,
// three blend stages, the queue and the output register before its results appear.
// each point yields two or four results, one per cycle while pop is held high,
// so the result port sets the sustained pace.
// a four-deep queue parts front and back; full rises only when it backs up.
// reset clears all valid state; no clearing pass is needed.
module trail_ribbon_mesh_builder_core import tmb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               push,
  output logic               full,
  input  logic [NUM_W-1:0]   point_number_i,
  input  logic [CNT_W-1:0]   point_count_i,
  input  logic signed [31:0] base_x_i,
  input  logic signed [31:0] base_y_i,
  input  logic signed [31:0] base_z_i,
  input  logic signed [31:0] tip_x_i,
  input  logic signed [31:0] tip_y_i,
  input  logic signed [31:0] tip_z_i,
  input  logic [31:0]        point_age_i,
  output logic               empty,
  input  logic               pop,
  output logic               result_kind_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic [15:0]        alpha_o,
  output logic [15:0]        tex_u_o,
  output logic               tex_v_o,
  output logic [IDX_W-1:0]   first_index_o,
  output logic [IDX_W-1:0]   second_index_o,
  output logic [IDX_W-1:0]   third_index_o,
  output logic               last_o
);

  cfg_t    cfg;
  logic    q_push, q_full, q_pop, q_empty;
  pt_rec_t q_wdata, q_rdata;

  tmb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tmb_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .push           (push),
    .full           (full),
    .point_number_i (point_number_i),
    .point_count_i  (point_count_i),
    .base_x_i       (base_x_i),
    .base_y_i       (base_y_i),
    .base_z_i       (base_z_i),
    .tip_x_i        (tip_x_i),
    .tip_y_i        (tip_y_i),
    .tip_z_i        (tip_z_i),
    .point_age_i    (point_age_i),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata),
    .q_full_i       (q_full)
  );

  tmb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  tmb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_data_i       (q_rdata),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .empty          (empty),
    .pop            (pop),
    .result_kind_o  (result_kind_o),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .alpha_o        (alpha_o),
    .tex_u_o        (tex_u_o),
    .tex_v_o        (tex_v_o),
    .first_index_o  (first_index_o),
    .second_index_o (second_index_o),
    .third_index_o  (third_index_o),
    .last_o         (last_o)
  );

endmodule

>>> tb/trail_ribbon_mesh_builder_core_tb.sv
// self-checking testbench for trail_ribbon_mesh_builder_core
// depends on tmb_pkg and the core; predicts every vertex and triangle record
module trail_ribbon_mesh_builder_core_tb;
  import tmb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 30;
  localparam logic [2:0] ADDR_LIFE_TIME   = 3'd0;
  localparam logic [2:0] ADDR_COLOR_ALPHA = 3'd4;

  typedef struct packed {
    logic [NUM_W-1:0]   num;
    logic [CNT_W-1:0]   cnt;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic signed [31:0] bz;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
    logic [31:0]        age;
  } trail_point_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [15:0]        alpha;
    logic [15:0]        u;
    logic               v;
    logic [IDX_W-1:0]   i0;
    logic [IDX_W-1:0]   i1;
    logic [IDX_W-1:0]   i2;
    logic               last;
  } mesh_rec_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic full;
  trail_point_t pt = '0;
  logic empty;
  logic pop = 1'b0;
  mesh_rec_t got;

  logic [31:0] life_reg = 32'd65536;
  logic [15:0] alpha_reg = 16'd32768;
  mesh_rec_t   mesh_q[$];
  int          errors = 0;
  int          pop_stall = 0;
  bit          no_stall = 1'b0;
  int          points_sent = 0;

  trail_ribbon_mesh_builder_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .push(push), .full(full),
    .point_number_i(pt.num), .point_count_i(pt.cnt),
    .base_x_i(pt.bx), .base_y_i(pt.by), .base_z_i(pt.bz),
    .tip_x_i(pt.tx), .tip_y_i(pt.ty), .tip_z_i(pt.tz),
    .point_age_i(pt.age),
    .empty(empty), .pop(pop),
    .result_kind_o(got.kind), .pos_x_o(got.px), .pos_y_o(got.py), .pos_z_o(got.pz),
    .alpha_o(got.alpha), .tex_u_o(got.u), .tex_v_o(got.v),
    .first_index_o(got.i0), .second_index_o(got.i1), .third_index_o(got.i2),
    .last_o(got.last)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #2ms;
    $display("== FAIL ==");
    $finish;
  end

  // tip pulled toward base, rounded half up
  function automatic logic [31:0] pull_tip(input logic signed [31:0] b,
                                           input logic signed [31:0] t,
                                           input longint ratio);
    longint prod, q;
    prod = (longint'(t) - longint'(b)) * ratio + 64'sd16384;
    if (prod >= 0) q = prod / 32768;
    else q = -((-prod + 32767) / 32768);
    return 32'(longint'(b) + q);
  endfunction

  // append one expected record at the tail
  function automatic void queue_rec(input mesh_rec_t r);
    mesh_q.insert(mesh_q.size(), r);
  endfunction

  function automatic void predict_mesh(input trail_point_t p);
    longint cnt, u, ratio, a, q;
    logic [6:0] b;
    mesh_rec_t r;
    cnt = (p.cnt > TRAIL_POINTS) ? TRAIL_POINTS : p.cnt;
    if (cnt < 2 || p.num >= cnt) return;
    u = (longint'(p.num) * 32768) / (cnt - 1);
    if (life_reg == 0) ratio = 0;
    else begin
      q = longint'({p.age, 15'b0}) / longint'(life_reg);
      ratio = (q < 32768) ? 32768 - q : 0;
    end
    a = (alpha_reg > Q15_ONE) ? 32768 : alpha_reg;
    a = (a * ratio + 16384) >>> 15;
    r = '0;
    r.kind = KIND_VERTEX;
    r.alpha = 16'(a);
    r.u = 16'(u);
    r.px = p.bx; r.py = p.by; r.pz = p.bz;
    queue_rec(r);
    r.v = 1'b1;
    r.px = pull_tip(p.bx, p.tx, ratio);
    r.py = pull_tip(p.by, p.ty, ratio);
    r.pz = pull_tip(p.bz, p.tz, ratio);
    r.last = (p.num == 0);
    queue_rec(r);
    if (p.num != 0) begin
      b = 7'(2 * p.num - 2);
      r = '0;
      r.kind = KIND_TRIANGLE;
      r.i0 = b; r.i1 = b + 7'd1; r.i2 = b + 7'd2;
      queue_rec(r);
      r.i0 = b + 7'd2; r.i2 = b + 7'd3; r.last = 1'b1;
      queue_rec(r);
    end
  endfunction

  // result side: random stalls per request unless no_stall is set, checked against oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (mesh_q.size() == 0) begin
        $display("%0t unexpected result act %p", $realtime, got);
        errors++;
      end else begin
        if (got !== mesh_q[0]) begin
          $display("%0t mismatch exp %p act %p", $realtime, mesh_q[0], got);
          errors++;
        end
        void'(mesh_q.pop_front());
      end
      pop_stall = no_stall ? 0 : $urandom_range(0, 8);
    end
    if (!rst_ni) pop <= 1'b0;
    else if (pop_stall > 0 && !(pop && !empty)) begin
      pop_stall--;
      pop <= 1'b0;
    end else if (pop && !empty && pop_stall > 0) pop <= 1'b0;
    else pop <= 1'b1;
  end

  task automatic send_point(input trail_point_t p, input bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pt <= p;
    push <= 1'b1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    predict_mesh(p);
    points_sent++;
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (mesh_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_LIFE_TIME) life_reg = data;
    else alpha_reg = data[15:0];
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      1: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_age();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return (life_reg == 0) ? $urandom : $urandom_range(0, life_reg);
      default: return $urandom_range(0, 32'h0002_0000);
    endcase
  endfunction

  function automatic trail_point_t make_point(input int num, input int cnt);
    trail_point_t p;
    p.num = NUM_W'(num);
    p.cnt = CNT_W'(cnt);
    p.bx = rand_pos(); p.by = rand_pos(); p.bz = rand_pos();
    p.tx = rand_pos(); p.ty = rand_pos(); p.tz = rand_pos();
    p.age = rand_age();
    return p;
  endfunction

  task automatic test_directed();
    trail_point_t p;
    // short trails and points beyond the count give nothing; the points with counts of 127 and 2 give results
    send_point(make_point(0, 0));
    send_point(make_point(0, 1));
    send_point(make_point(5, 4));
    send_point(make_point(63, 127));
    send_point(make_point(0, 2));
    send_point(make_point(1, 2));
    // count above capacity saturates
    send_point(make_point(40, 100));
    send_point(make_point(63, 64));
    p = make_point(62, 64);
    p.bx = 32'h8000_0000; p.tx = 32'h7fff_ffff;
    p.by = 32'h7fff_ffff; p.ty = 32'h8000_0000;
    p.bz = '0; p.tz = 32'hffff_ffff; p.age = '0;
    send_point(p);
    p.age = 32'hffff_ffff;
    send_point(p);
    p.age = 32'h0000_8000; p.num = 6'd31;
    send_point(p);
    p.age = 32'h0001_0000; p.num = 6'd1;
    send_point(p);
    wait_idle();
  endtask

  task automatic test_config_extremes();
    trail_point_t p;
    // zero lifetime with alpha above one, then minimum lifetime with zero alpha, then maximum lifetime with alpha one
    write_reg(ADDR_LIFE_TIME, 32'd0);
    write_reg(ADDR_COLOR_ALPHA, 32'h0000_ffff);
    for (int i = 0; i < 3; i++) send_point(make_point(i, 3));
    wait_idle();
    write_reg(ADDR_LIFE_TIME, 32'd1);
    write_reg(ADDR_COLOR_ALPHA, 32'd0);
    p = make_point(2, 10); p.age = 32'd0;
    send_point(p);
    send_point(make_point(3, 10));
    wait_idle();
    write_reg(ADDR_LIFE_TIME, 32'hffff_ffff);
    write_reg(ADDR_COLOR_ALPHA, 32'd32768);
    for (int i = 0; i < 4; i++) send_point(make_point(i, 4));
    wait_idle();
  endtask

  task automatic test_random_trails(input int target);
    int cnt, settings_done;
    settings_done = 0;
    while (points_sent < target) begin
      if ($urandom_range(0, 5) == 0) begin
        // noise: arbitrary number and count
        send_point(make_point($urandom_range(0, 63), $urandom_range(0, 127)));
      end else begin
        cnt = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 12);
        for (int i = 0; i < ((cnt > 64) ? 64 : cnt) && points_sent < target; i++)
          send_point(make_point(i, cnt), !no_stall);
      end
      if (points_sent > target / 3 && settings_done == 0) begin
        // drain fully, then run a stretch with no pop stalls and no gaps before trail points
        wait_idle();
        write_reg(ADDR_LIFE_TIME, $urandom_range(1, 32'h0004_0000));
        write_reg(ADDR_COLOR_ALPHA, $urandom_range(0, 32768));
        no_stall = 1'b1;
        settings_done = 1;
      end else if (points_sent > 2 * target / 3 && settings_done == 1) begin
        wait_idle();
        no_stall = 1'b0;
        write_reg(ADDR_LIFE_TIME, 32'd65536);
        write_reg(ADDR_COLOR_ALPHA, $urandom_range(16384, 65535));
        settings_done = 2;
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_random_trails(230);
    if (errors == 0 && mesh_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tmb_pkg.sv
rtl/core/tmb_cfg.sv
rtl/core/tmb_front.sv
rtl/core/tmb_queue.sv
rtl/core/tmb_back.sv
rtl/core/trail_ribbon_mesh_builder_core.sv
tb/trail_ribbon_mesh_builder_core_tb.sv
